// ===== rtl/cubic_bezier_sampler_core_defines.svh =====
// Assertion macros for the checker file of the Bezier sampler.
// No dependencies; pulled in by `include where assertions are written.
`ifndef CUBIC_BEZIER_SAMPLER_CORE_DEFINES_SVH
`define CUBIC_BEZIER_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define CBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cbs_pkg.sv =====
// Package for the cubic Bezier sampler: widths, types, opcodes and tables.
// No dependencies; imported by every module of the block.
package cbs_pkg;

  localparam int COORD_W     = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int T_W         = T_FRAC_BITS + 1;
  localparam int MAX_POINTS  = 64;
  localparam int IDX_W       = 6;
  localparam int PC_W        = 7;
  localparam int COLOUR_W    = 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [T_W-1:0]            t_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [PC_W-1:0]           pcnt_t;

  localparam t_t      T_ONE       = t_t'(1) << T_FRAC_BITS;
  localparam pcnt_t   PC_RESET    = pcnt_t'(30);
  localparam pcnt_t   PC_MIN      = pcnt_t'(2);
  localparam pcnt_t   PC_MAX      = pcnt_t'(MAX_POINTS);
  localparam logic [COLOUR_W-1:0] COLOUR_FULL = 8'hFF;

  // Micro-program: one axis of de Casteljau on a four-entry rotating queue
  localparam int PROG_W = 4;
  localparam logic [PROG_W-1:0] PROG_LAST = 4'd8;
  localparam logic OP_LERP = 1'b0;
  localparam logic OP_DROP = 1'b1;

  // LERP: head pair -> tail, shift by one. DROP: rotate by one.
  function automatic logic prog_op(input logic [PROG_W-1:0] pc);
    logic op;
    case (pc)
      4'd3, 4'd6, 4'd7: op = OP_DROP;
      default:          op = OP_LERP;
    endcase
    return op;
  endfunction

  // floor(2^16 / k) for k = 1..63
  function automatic t_t step_lut(input idx_t k);
    t_t s;
    case (k)
      6'd1:  s = 17'd65536; 6'd2:  s = 17'd32768; 6'd3:  s = 17'd21845;
      6'd4:  s = 17'd16384; 6'd5:  s = 17'd13107; 6'd6:  s = 17'd10922;
      6'd7:  s = 17'd9362;  6'd8:  s = 17'd8192;  6'd9:  s = 17'd7281;
      6'd10: s = 17'd6553;  6'd11: s = 17'd5957;  6'd12: s = 17'd5461;
      6'd13: s = 17'd5041;  6'd14: s = 17'd4681;  6'd15: s = 17'd4369;
      6'd16: s = 17'd4096;  6'd17: s = 17'd3855;  6'd18: s = 17'd3640;
      6'd19: s = 17'd3449;  6'd20: s = 17'd3276;  6'd21: s = 17'd3120;
      6'd22: s = 17'd2978;  6'd23: s = 17'd2849;  6'd24: s = 17'd2730;
      6'd25: s = 17'd2621;  6'd26: s = 17'd2520;  6'd27: s = 17'd2427;
      6'd28: s = 17'd2340;  6'd29: s = 17'd2259;  6'd30: s = 17'd2184;
      6'd31: s = 17'd2114;  6'd32: s = 17'd2048;  6'd33: s = 17'd1985;
      6'd34: s = 17'd1927;  6'd35: s = 17'd1872;  6'd36: s = 17'd1820;
      6'd37: s = 17'd1771;  6'd38: s = 17'd1724;  6'd39: s = 17'd1680;
      6'd40: s = 17'd1638;  6'd41: s = 17'd1598;  6'd42: s = 17'd1560;
      6'd43: s = 17'd1524;  6'd44: s = 17'd1489;  6'd45: s = 17'd1456;
      6'd46: s = 17'd1424;  6'd47: s = 17'd1394;  6'd48: s = 17'd1365;
      6'd49: s = 17'd1337;  6'd50: s = 17'd1310;  6'd51: s = 17'd1285;
      6'd52: s = 17'd1260;  6'd53: s = 17'd1236;  6'd54: s = 17'd1213;
      6'd55: s = 17'd1191;  6'd56: s = 17'd1170;  6'd57: s = 17'd1149;
      6'd58: s = 17'd1129;  6'd59: s = 17'd1110;  6'd60: s = 17'd1092;
      6'd61: s = 17'd1074;  6'd62: s = 17'd1057;  6'd63: s = 17'd1040;
      default: s = T_ONE;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/cbs_if.sv =====
// Valid/ready channel interfaces for control points in and curve samples out.
// Depends on cbs_pkg for the payload types.
interface cbs_in_if import cbs_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t handle_one_x;
  coord_t handle_one_y;
  coord_t handle_two_x;
  coord_t handle_two_y;
  coord_t end_x;
  coord_t end_y;

  modport source (
    output valid, start_x, start_y, handle_one_x, handle_one_y,
           handle_two_x, handle_two_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, handle_one_x, handle_one_y,
           handle_two_x, handle_two_y, end_x, end_y,
    output ready
  );
endinterface

interface cbs_out_if import cbs_pkg::*; ();
  logic                valid;
  logic                ready;
  idx_t                sample_index;
  coord_t              curve_x;
  coord_t              curve_y;
  logic [COLOUR_W-1:0] red;
  logic [COLOUR_W-1:0] green;
  logic [COLOUR_W-1:0] blue;
  logic                last;

  modport source (
    output valid, sample_index, curve_x, curve_y, red, green, blue, last,
    input  ready
  );
  modport sink (
    input  valid, sample_index, curve_x, curve_y, red, green, blue, last,
    output ready
  );
endinterface

// ===== rtl/cbs_lerp.sv =====
// Shared interpolation unit: a + floor(t*(b-a) / 2^16), multiply registered.
// Depends on cbs_pkg. Result is valid the cycle after en.
module cbs_lerp import cbs_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  coord_t a,
  input  coord_t b,
  input  t_t     t,
  output coord_t res
);

  localparam int PROD_W = COORD_W + 1 + T_W + 1;

  logic signed [COORD_W:0]   diff;
  logic signed [T_W:0]       t_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_r;
  coord_t                    a_r;
  logic signed [COORD_W+1:0] sum;

  // difference and product, registered
  assign diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
  assign t_s  = $signed({1'b0, t});
  assign prod = diff * t_s;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod;
      a_r    <= a;
    end
  end

  // floor shift is an arithmetic slice; result always lies between a and b
  assign sum = {{2{a_r[COORD_W-1]}}, a_r} + prod_r[T_FRAC_BITS+COORD_W+1:T_FRAC_BITS];
  assign res = sum[COORD_W-1:0];

endmodule

// ===== rtl/cubic_bezier_sampler_core.sv =====
// Cubic Bezier sampler: point_count samples per control-point beat, de Casteljau.
// Per sample: load the points, run the x program, then the y program, then offer
// the sample; no new beat is taken until the last sample is accepted. The pace is
// set by the one shared multiplier doing all twelve interpolations of a sample.
// Reset (rst_n low, synchronous): sequencer to idle, point_count back to 30.
module cubic_bezier_sampler_core import cbs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  cbs_in_if.sink       in_ch,
  cbs_out_if.source    out_ch,
  input  logic         cfg_we,
  input  pcnt_t        cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [PROG_W-1:0]   pc_r, pc_nxt;
  logic                axis_r, axis_nxt;
  idx_t                idx_r, idx_nxt;
  t_t                  tacc_r, tacc_nxt;
  t_t                  t_r, t_nxt;
  logic [COLOUR_W-1:0] red_r, red_nxt;
  pcnt_t               pcnt_r;
  idx_t                last_r;
  t_t                  step_r;
  coord_t              cx_r [4];
  coord_t              cy_r [4];
  coord_t              qx_r [4];
  coord_t              qy_r [4];
  coord_t              qx_nxt [4];
  coord_t              qy_nxt [4];

  pcnt_t               n_eff;
  idx_t                n_last;
  logic                in_take;
  logic                step_done;
  logic                lerp_en;
  coord_t              head_a, head_b, lerp_res;
  t_t                  t_sel;
  logic [T_W+7:0]      red_w;

  assign in_take = in_ch.valid && in_ch.ready;

  // point count clamped to 2..MAX_POINTS
  always_comb begin
    if (pcnt_r < PC_MIN) begin
      n_eff = PC_MIN;
    end else if (pcnt_r > PC_MAX) begin
      n_eff = PC_MAX;
    end else begin
      n_eff = pcnt_r;
    end
  end
  assign n_last = idx_t'(n_eff - pcnt_t'(1));

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= PC_RESET;
    end else if (cfg_we) begin
      pcnt_r <= cfg_wdata;
    end
  end

  // control points and run length captured on the input beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      cx_r[0] <= in_ch.start_x;
      cx_r[1] <= in_ch.handle_one_x;
      cx_r[2] <= in_ch.handle_two_x;
      cx_r[3] <= in_ch.end_x;
      cy_r[0] <= in_ch.start_y;
      cy_r[1] <= in_ch.handle_one_y;
      cy_r[2] <= in_ch.handle_two_y;
      cy_r[3] <= in_ch.end_y;
      last_r  <= n_last;
      step_r  <= step_lut(n_last);
    end
  end

  // shared interpolation unit works on the head pair of the active queue
  assign head_a = axis_r ? qy_r[0] : qx_r[0];
  assign head_b = axis_r ? qy_r[1] : qx_r[1];

  cbs_lerp u_lerp (
    .clk (clk),
    .en  (lerp_en),
    .a   (head_a),
    .b   (head_b),
    .t   (t_r),
    .res (lerp_res)
  );

  // parameter of the sample about to start; the final one lands on 1.0
  assign t_sel = (idx_r == last_r) ? T_ONE : tacc_r;

  // red = floor(255*t / 2^16)
  assign red_w = {t_sel, 8'b0} - {8'b0, t_sel};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    axis_nxt  = axis_r;
    idx_nxt   = idx_r;
    tacc_nxt  = tacc_r;
    t_nxt     = t_r;
    red_nxt   = red_r;
    qx_nxt    = qx_r;
    qy_nxt    = qy_r;
    lerp_en   = 1'b0;
    step_done = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_LOAD;
          idx_nxt   = '0;
          tacc_nxt  = '0;
        end
      end
      S_LOAD: begin
        t_nxt     = t_sel;
        red_nxt   = red_w[T_FRAC_BITS+COLOUR_W-1:T_FRAC_BITS];
        qx_nxt    = cx_r;
        qy_nxt    = cy_r;
        pc_nxt    = '0;
        axis_nxt  = 1'b0;
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        if (prog_op(pc_r) == OP_LERP) begin
          lerp_en   = 1'b1;
          state_nxt = S_WRITE;
        end else begin
          // rotate the active queue by one
          for (int j = 0; j < 3; j++) begin
            if (axis_r) begin
              qy_nxt[j] = qy_r[j+1];
            end else begin
              qx_nxt[j] = qx_r[j+1];
            end
          end
          if (axis_r) begin
            qy_nxt[3] = qy_r[0];
          end else begin
            qx_nxt[3] = qx_r[0];
          end
          step_done = 1'b1;
        end
      end
      S_WRITE: begin
        // shift in the interpolation result at the tail
        for (int j = 0; j < 3; j++) begin
          if (axis_r) begin
            qy_nxt[j] = qy_r[j+1];
          end else begin
            qx_nxt[j] = qx_r[j+1];
          end
        end
        if (axis_r) begin
          qy_nxt[3] = lerp_res;
        end else begin
          qx_nxt[3] = lerp_res;
        end
        step_done = 1'b1;
        state_nxt = S_ISSUE;
      end
      S_EMIT: begin
        if (out_ch.ready) begin
          if (idx_r == last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + idx_t'(1);
            tacc_nxt  = tacc_r + step_r;
            state_nxt = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // program counter: x axis, then y axis, then offer the sample
    if (step_done) begin
      if (pc_r == PROG_LAST) begin
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          pc_nxt    = '0;
          state_nxt = S_ISSUE;
        end else begin
          state_nxt = S_EMIT;
        end
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      axis_r  <= 1'b0;
      idx_r   <= '0;
      tacc_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      axis_r  <= axis_nxt;
      idx_r   <= idx_nxt;
      tacc_r  <= tacc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r   <= t_nxt;
    red_r <= red_nxt;
    qx_r  <= qx_nxt;
    qy_r  <= qy_nxt;
  end

  // channel outputs; the finished point sits at the queue tail
  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = (state_r == S_EMIT);
  assign out_ch.sample_index = idx_r;
  assign out_ch.curve_x      = qx_r[3];
  assign out_ch.curve_y      = qy_r[3];
  assign out_ch.red          = red_r;
  assign out_ch.green        = COLOUR_FULL;
  assign out_ch.blue         = COLOUR_FULL;
  assign out_ch.last         = (idx_r == last_r);

endmodule

// ===== rtl/cbs_checker.sv =====
// Port-level checker for the Bezier sampler, bound to the top level.
// Depends on cbs_pkg and the assertion macros in the defines header.
`include "cubic_bezier_sampler_core_defines.svh"

module cbs_checker import cbs_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input logic   out_last,
  input idx_t   out_sample_index,
  input coord_t out_curve_x
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // one run at a time: never accepting while a sample is on offer
  `CBS_ASSERT_NOW(a_no_overlap, clk, rst_n, in_ready, !out_valid, "ready while sample offered")

  // an accepted beat starts a multi-cycle run
  `CBS_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_beat, !in_ready && !out_valid, "run did not start")

  // the final sample returns the block to idle, any other keeps it busy
  `CBS_ASSERT_NEXT(a_last_idle, clk, rst_n, out_beat, in_ready == $past(out_last), "idle mismatch after sample")

  // a stalled sample holds
  `CBS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample_index) && $stable(out_curve_x), "stalled sample changed")

endmodule

bind cubic_bezier_sampler_core cbs_checker u_cbs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_last         (out_ch.last),
  .out_sample_index (out_ch.sample_index),
  .out_curve_x      (out_ch.curve_x)
);
